### rtl/mhq_pkg.sv
// Shared types and codes for the four-ary min-heap priority queue.
// Holds the entry and result layouts, status and request codes and FSM states.
// No dependencies; every other file in rtl refers to it by scoped names.
package mhq_pkg;

   localparam int KEY_W = 16;
   localparam int PAY_W = 16;
   localparam int OCC_W = 11;

   // One heap word: key in the upper half, payload handle in the lower half.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_DIV,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_LAST_RD,
      ST_POP_LAST,
      ST_DN_START,
      ST_DN_SCAN,
      ST_DN_DEC,
      ST_DONE
   } state_type;

endpackage

### rtl/mhq_mem.sv
// Heap storage: one synchronous memory with one write and one read port.
// Read data is registered, so it appears in the cycle after the address.
// Depends on mhq_pkg for the entry layout.
module mhq_mem #(
   parameter int HEAP_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(HEAP_DEPTH)-1:0] wr_addr,
   input  mhq_pkg::entry_type           wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(HEAP_DEPTH)-1:0] rd_addr,
   output mhq_pkg::entry_type           rd_data
);

   mhq_pkg::entry_type mem_ff [HEAP_DEPTH];
   mhq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mhq_ctrl.sv
// Sequencer for push (sift-up) and pop (sift-down) over the heap memory.
// Keeps the moving entry in a register and writes it once at its final slot.
// Depends on mhq_pkg; drives the ports of mhq_mem.
module mhq_ctrl #(
   parameter int HEAP_DEPTH = 1024,
   parameter int ARITY      = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_accept,
   input  logic                             req_type,
   input  logic [mhq_pkg::KEY_W-1:0]        req_key,
   input  logic [mhq_pkg::PAY_W-1:0]        req_payload,
   input  logic                             res_take,
   output logic                             ctrl_idle,
   output logic                             res_valid,
   output mhq_pkg::result_type              result,
   output logic                             mem_wr_en,
   output logic [$clog2(HEAP_DEPTH)-1:0]    mem_wr_addr,
   output mhq_pkg::entry_type               mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(HEAP_DEPTH)-1:0]    mem_rd_addr,
   input  mhq_pkg::entry_type               mem_rd_data
);

   localparam int ADDR_W  = $clog2(HEAP_DEPTH);
   localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
   localparam int LOG_A   = $clog2(ARITY);
   localparam int FIRST_W = ADDR_W + LOG_A + 1;
   localparam int CI_W    = $clog2(ARITY + 1);
   // Parent index by reciprocal multiplication; exact for every index below 2**ADDR_W.
   localparam int SHIFT   = ADDR_W + LOG_A;
   localparam int RECIP_W = ADDR_W + 2;
   localparam int PROD_W  = ADDR_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** SHIFT) + ARITY - 1) / ARITY);

   mhq_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]   par_ff, par_in;
   mhq_pkg::entry_type  moving_ff, moving_in;
   logic [FIRST_W-1:0]  first_ff, first_in;
   logic [CI_W-1:0]     ci_ff, ci_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                cmp_first_ff, cmp_first_in;
   mhq_pkg::entry_type  best_ff, best_in;
   logic [ADDR_W-1:0]   best_idx_ff, best_idx_in;
   logic [mhq_pkg::KEY_W-1:0] res_key_ff, res_key_in;
   logic [mhq_pkg::PAY_W-1:0] res_pay_ff, res_pay_in;
   mhq_pkg::status_type res_status_ff, res_status_in;

   logic [ADDR_W-1:0]  pos_m1;
   logic [PROD_W-1:0]  par_prod;
   logic [ADDR_W-1:0]  par_w;
   logic [FIRST_W-1:0] first_w;
   logic [FIRST_W-1:0] child_w;
   logic [FIRST_W-1:0] n_w;
   logic               has_child;
   logic               issue_now;
   logic               heap_full;
   logic               heap_empty;
   logic               up_less;
   logic               dn_swap;
   logic               scan_better;

   assign pos_m1      = pos_ff - ADDR_W'(1);
   assign par_prod    = PROD_W'(pos_m1) * PROD_W'(RECIP);
   assign par_w       = ADDR_W'(par_prod >> SHIFT);
   assign first_w     = FIRST_W'(pos_ff) * FIRST_W'(ARITY) + FIRST_W'(1);
   assign child_w     = first_ff + FIRST_W'(ci_ff);
   assign n_w         = FIRST_W'(count_ff);
   assign has_child   = first_w < n_w;
   assign issue_now   = (ci_ff < CI_W'(ARITY)) && (child_w < n_w);
   assign heap_full   = count_ff == CNT_W'(HEAP_DEPTH);
   assign heap_empty  = count_ff == '0;
   assign up_less     = moving_ff.key < mem_rd_data.key;
   assign dn_swap     = moving_ff.key > best_ff.key;
   assign scan_better = cmp_first_ff || (mem_rd_data.key < best_ff.key);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhq_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_type == mhq_pkg::REQ_PUSH) begin
                  state_in = heap_full ? mhq_pkg::ST_DONE : mhq_pkg::ST_UP_DIV;
               end else begin
                  state_in = heap_empty ? mhq_pkg::ST_DONE : mhq_pkg::ST_POP_LAST_RD;
               end
            end
         end
         mhq_pkg::ST_UP_DIV: begin
            state_in = (pos_ff == '0) ? mhq_pkg::ST_DONE : mhq_pkg::ST_UP_RD;
         end
         mhq_pkg::ST_UP_RD: begin
            state_in = mhq_pkg::ST_UP_CMP;
         end
         mhq_pkg::ST_UP_CMP: begin
            state_in = up_less ? mhq_pkg::ST_UP_DIV : mhq_pkg::ST_DONE;
         end
         mhq_pkg::ST_POP_LAST_RD: begin
            state_in = mhq_pkg::ST_POP_LAST;
         end
         mhq_pkg::ST_POP_LAST: begin
            state_in = mhq_pkg::ST_DN_START;
         end
         mhq_pkg::ST_DN_START: begin
            state_in = has_child ? mhq_pkg::ST_DN_SCAN : mhq_pkg::ST_DONE;
         end
         mhq_pkg::ST_DN_SCAN: begin
            state_in = issue_now ? mhq_pkg::ST_DN_SCAN : mhq_pkg::ST_DN_DEC;
         end
         mhq_pkg::ST_DN_DEC: begin
            state_in = dn_swap ? mhq_pkg::ST_DN_START : mhq_pkg::ST_DONE;
         end
         mhq_pkg::ST_DONE: begin
            if (res_take) begin
               state_in = mhq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhq_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory port controls and handshake outputs. The sequence never reads an
   // entry in the cycle it is written, so the memory needs no forwarding.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = pos_ff;
      mem_wr_data = moving_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      ctrl_idle   = 1'b0;
      res_valid   = 1'b0;
      case (state_ff)
         mhq_pkg::ST_IDLE: begin
            ctrl_idle = 1'b1;
            mem_rd_en = req_accept && (req_type == mhq_pkg::REQ_POP) && !heap_empty;
         end
         mhq_pkg::ST_UP_DIV: begin
            mem_wr_en = pos_ff == '0;
         end
         mhq_pkg::ST_UP_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = par_ff;
         end
         mhq_pkg::ST_UP_CMP: begin
            mem_wr_en = 1'b1;
            if (up_less) begin
               mem_wr_data = mem_rd_data;
            end
         end
         mhq_pkg::ST_POP_LAST_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(count_ff);
         end
         mhq_pkg::ST_POP_LAST: begin
            mem_wr_en = 1'b0;
         end
         mhq_pkg::ST_DN_START: begin
            mem_wr_en = !has_child;
         end
         mhq_pkg::ST_DN_SCAN: begin
            mem_rd_en   = issue_now;
            mem_rd_addr = ADDR_W'(child_w);
         end
         mhq_pkg::ST_DN_DEC: begin
            mem_wr_en = 1'b1;
            if (dn_swap) begin
               mem_wr_data = best_ff;
            end
         end
         mhq_pkg::ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            ctrl_idle = 1'b0;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      par_in        = par_ff;
      moving_in     = moving_ff;
      first_in      = first_ff;
      ci_in         = ci_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      cmp_first_in  = cmp_first_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         mhq_pkg::ST_IDLE: begin
            if (req_accept) begin
               res_key_in    = '0;
               res_pay_in    = '0;
               res_status_in = mhq_pkg::STATUS_OK;
               if (req_type == mhq_pkg::REQ_PUSH) begin
                  if (heap_full) begin
                     res_status_in = mhq_pkg::STATUS_FULL;
                  end else begin
                     moving_in.key     = req_key;
                     moving_in.payload = req_payload;
                     pos_in            = ADDR_W'(count_ff);
                     count_in          = count_ff + CNT_W'(1);
                  end
               end else begin
                  if (heap_empty) begin
                     res_status_in = mhq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         mhq_pkg::ST_UP_DIV: begin
            par_in = par_w;
         end
         mhq_pkg::ST_UP_CMP: begin
            if (up_less) begin
               pos_in = par_ff;
            end
         end
         mhq_pkg::ST_POP_LAST_RD: begin
            // The root read issued at acceptance lands here.
            res_key_in = mem_rd_data.key;
            res_pay_in = mem_rd_data.payload;
         end
         mhq_pkg::ST_POP_LAST: begin
            moving_in = mem_rd_data;
            pos_in    = '0;
         end
         mhq_pkg::ST_DN_START: begin
            first_in = first_w;
            ci_in    = '0;
         end
         mhq_pkg::ST_DN_SCAN: begin
            // Reads go out one child per cycle; each is compared in the cycle after its read.
            cmp_vld_in   = issue_now;
            cmp_idx_in   = ADDR_W'(child_w);
            cmp_first_in = ci_ff == '0;
            if (issue_now) begin
               ci_in = ci_ff + CI_W'(1);
            end
            if (cmp_vld_ff && scan_better) begin
               best_in     = mem_rd_data;
               best_idx_in = cmp_idx_ff;
            end
         end
         mhq_pkg::ST_DN_DEC: begin
            if (dn_swap) begin
               pos_in = best_idx_ff;
            end
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mhq_pkg::ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      par_ff        <= par_in;
      moving_ff     <= moving_in;
      first_ff      <= first_in;
      ci_ff         <= ci_in;
      cmp_idx_ff    <= cmp_idx_in;
      cmp_first_ff  <= cmp_first_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      res_status_ff <= res_status_in;
   end

   assign result.key       = res_key_ff;
   assign result.payload   = res_pay_ff;
   assign result.status    = res_status_ff;
   assign result.occupancy = mhq_pkg::OCC_W'(count_ff);

endmodule

### rtl/four_ary_min_heap_queue.sv
// Top level of the d-ary min-heap priority queue (four children per node by default).
// Instantiates mhq_ctrl and mhq_mem and holds the response output register.
// Depends on mhq_pkg.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_type, req_key, req_payload
//   rsp      out        rsp_valid/rsp_stall   rsp_out_key, rsp_out_payload,
//                                             rsp_status, rsp_occupancy
//
// One transaction is in work at a time; req_stall is high from acceptance until the
// result moves to the output register. A rejected request goes straight to the result;
// a push reads and compares the parent at each level climbed, and a pop reads the last
// entry, then at each level descended reads its c children, one per cycle, and compares.
// The next request can be accepted once the result has moved, even while rsp_stall holds it.
// Reset clears the entry count, the state and the response valid; memory is not cleared.
module four_ary_min_heap_queue #(
   parameter int HEAP_DEPTH = 1024,
   parameter int ARITY      = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic [mhq_pkg::KEY_W-1:0] req_key,
   input  logic [mhq_pkg::PAY_W-1:0] req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [mhq_pkg::KEY_W-1:0] rsp_out_key,
   output logic [mhq_pkg::PAY_W-1:0] rsp_out_payload,
   output logic [1:0]                rsp_status,
   output logic [mhq_pkg::OCC_W-1:0] rsp_occupancy
);

   localparam int ADDR_W = $clog2(HEAP_DEPTH);

   logic                ctrl_idle;
   logic                res_valid;
   logic                res_take;
   logic                req_accept;
   mhq_pkg::result_type result;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   mhq_pkg::entry_type  mem_wr_data;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   mhq_pkg::entry_type  mem_rd_data;

   logic                rsp_valid_ff, rsp_valid_in;
   mhq_pkg::result_type rsp_data_ff, rsp_data_in;

   assign req_stall  = !ctrl_idle;
   assign req_accept = req_valid && !req_stall;
   assign res_take   = res_valid && (!rsp_valid_ff || !rsp_stall);

   mhq_ctrl #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .ARITY      (ARITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_type    (req_type),
      .req_key     (req_key),
      .req_payload (req_payload),
      .res_take    (res_take),
      .ctrl_idle   (ctrl_idle),
      .res_valid   (res_valid),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   mhq_mem #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_data_ff.key;
   assign rsp_out_payload = rsp_data_ff.payload;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_occupancy   = rsp_data_ff.occupancy;

endmodule

### rtl/mhq_checker.sv
// Port-level checks for four_ary_min_heap_queue, attached by the bind below.
// Watches only the top-level ports; depends on mhq_pkg for status codes.
module mhq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [mhq_pkg::KEY_W-1:0] rsp_out_key,
   input logic [mhq_pkg::PAY_W-1:0] rsp_out_payload,
   input logic [1:0]                rsp_status,
   input logic [mhq_pkg::OCC_W-1:0] rsp_occupancy
);

   // A held response keeps every field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_out_payload) && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   // Only one transaction is in work: acceptance closes the request side.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a transaction was in work");

   // An empty pop leaves an empty heap and returns no entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mhq_pkg::STATUS_EMPTY) |->
         (rsp_out_key == '0) && (rsp_out_payload == '0) && (rsp_occupancy == '0))
      else $error("empty pop returned data or nonzero occupancy");

   // A rejected push returns no entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mhq_pkg::STATUS_FULL) |->
         (rsp_out_key == '0) && (rsp_out_payload == '0))
      else $error("rejected push returned data");

   // Reset drops any pending response.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind four_ary_min_heap_queue mhq_checker u_mhq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_key     (rsp_out_key),
   .rsp_out_payload (rsp_out_payload),
   .rsp_status      (rsp_status),
   .rsp_occupancy   (rsp_occupancy)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for four_ary_min_heap_queue: directed and random push/pop traffic
// with random idle and stall gaps, checked against a behavioral 4-ary heap.
// Depends on rtl/mhq_pkg.sv and rtl/four_ary_min_heap_queue.sv.
module tb_top;

   localparam int HEAP_DEPTH     = 1024;
   localparam int ARITY          = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int KEY_W          = mhq_pkg::KEY_W;
   localparam int PAY_W          = mhq_pkg::PAY_W;
   localparam int OCC_W          = mhq_pkg::OCC_W;

   // Behavioral heap plus the queue of results it predicts, oldest first.
   class heap_scoreboard;
      mhq_pkg::entry_type  heap_entries [HEAP_DEPTH];
      int unsigned         entry_total;
      mhq_pkg::result_type expected_results [$];
      int unsigned         fail_count;

      function void note_request(logic kind, logic [KEY_W-1:0] key,
                                 logic [PAY_W-1:0] payload);
         mhq_pkg::result_type res;
         mhq_pkg::entry_type  tmp;
         int unsigned pos;
         int unsigned parent;
         int unsigned first;
         int unsigned best;
         bit          done;
         res = '0;
         res.status = mhq_pkg::STATUS_OK;
         if (kind == mhq_pkg::REQ_PUSH) begin
            if (entry_total >= HEAP_DEPTH) begin
               res.status = mhq_pkg::STATUS_FULL;
            end else begin
               pos = entry_total;
               heap_entries[pos].key = key;
               heap_entries[pos].payload = payload;
               entry_total++;
               done = 0;
               while (pos > 0 && !done) begin
                  parent = (pos - 1) / ARITY;
                  if (heap_entries[pos].key < heap_entries[parent].key) begin
                     tmp = heap_entries[pos];
                     heap_entries[pos] = heap_entries[parent];
                     heap_entries[parent] = tmp;
                     pos = parent;
                  end else begin
                     done = 1;
                  end
               end
            end
         end else if (entry_total == 0) begin
            res.status = mhq_pkg::STATUS_EMPTY;
         end else begin
            res.key = heap_entries[0].key;
            res.payload = heap_entries[0].payload;
            entry_total--;
            heap_entries[0] = heap_entries[entry_total];
            pos = 0;
            done = 0;
            while (!done) begin
               first = ARITY * pos + 1;
               if (first >= entry_total) begin
                  done = 1;
               end else begin
                  // Leftmost smallest child wins; ties keep the earlier one.
                  best = first;
                  for (int i = 1; i < ARITY; i++) begin
                     if (first + i < entry_total &&
                         heap_entries[first + i].key < heap_entries[best].key) begin
                        best = first + i;
                     end
                  end
                  if (heap_entries[pos].key > heap_entries[best].key) begin
                     tmp = heap_entries[pos];
                     heap_entries[pos] = heap_entries[best];
                     heap_entries[best] = tmp;
                     pos = best;
                  end else begin
                     done = 1;
                  end
               end
            end
         end
         res.occupancy = entry_total[OCC_W-1:0];
         expected_results.push_back(res);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_result(logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload,
                                 logic [1:0] status, logic [OCC_W-1:0] occupancy);
         mhq_pkg::result_type want;
         if (expected_results.size() == 0) begin
            $error("result transaction with no request outstanding");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("rsp_out_key", want.key, key);
            compare_field("rsp_out_payload", want.payload, payload);
            compare_field("rsp_status", want.status, status);
            compare_field("rsp_occupancy", want.occupancy, occupancy);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_type = mhq_pkg::REQ_PUSH;
   logic [KEY_W-1:0]  req_key = '0;
   logic [PAY_W-1:0]  req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KEY_W-1:0]  rsp_out_key;
   logic [PAY_W-1:0]  rsp_out_payload;
   logic [1:0]        rsp_status;
   logic [OCC_W-1:0]  rsp_occupancy;

   heap_scoreboard sb;
   int             fill_level;
   bit             sender_calm;
   bit             receiver_calm;
   int             stall_left;
   int             quiet_cycles;

   four_ary_min_heap_queue #(
      .HEAP_DEPTH(HEAP_DEPTH),
      .ARITY(ARITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_key(rsp_out_key),
      .rsp_out_payload(rsp_out_payload),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Small keys show up often so that equal keys meet inside the heap.
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return KEY_W'($urandom_range(0, 7));
      return KEY_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [PAY_W-1:0] pick_payload();
      return PAY_W'($urandom_range(0, 65535));
   endfunction

   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [PAY_W-1:0] payload);
      int gap;
      if ($urandom_range(0, 99) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : pick_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_key <= key;
      req_payload <= payload;
      do @(posedge clock); while (req_stall);
      if (kind == mhq_pkg::REQ_PUSH && fill_level < HEAP_DEPTH) fill_level++;
      if (kind == mhq_pkg::REQ_POP && fill_level > 0) fill_level--;
   endtask

   task automatic send_random(input int push_percent);
      logic kind;
      kind = ($urandom_range(0, 99) < push_percent) ? mhq_pkg::REQ_PUSH : mhq_pkg::REQ_POP;
      send_request(kind, pick_key(), pick_payload());
   endtask

   // Receiver stall pattern, with calm stretches where it starts no new stalls.
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) receiver_calm = !receiver_calm;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!receiver_calm && $urandom_range(0, 9) < 3) stall_left = pick_gap();
      end
   end

   // Both channels are sampled at the edge; the result is checked before the
   // request of the same edge is noted, since it always belongs to an older one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_out_key, rsp_out_payload, rsp_status, rsp_occupancy);
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_type, req_key, req_payload);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("four_ary_min_heap_queue: mismatch");
         $finish;
      end
   end

   initial begin
      sb = new;
      fill_level = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pops, key and payload extremes, equal keys, full drain.
      send_request(mhq_pkg::REQ_POP, 16'h0000, 16'h0000);
      send_request(mhq_pkg::REQ_POP, 16'hFFFF, 16'hFFFF);
      send_request(mhq_pkg::REQ_PUSH, 16'hFFFF, 16'hFFFF);
      send_request(mhq_pkg::REQ_PUSH, 16'h0000, 16'h0000);
      send_request(mhq_pkg::REQ_PUSH, 16'h8000, 16'h5A5A);
      send_request(mhq_pkg::REQ_PUSH, 16'h0005, 16'h0001);
      send_request(mhq_pkg::REQ_PUSH, 16'h0005, 16'h0002);
      send_request(mhq_pkg::REQ_PUSH, 16'h0005, 16'h0003);
      send_request(mhq_pkg::REQ_PUSH, 16'h0001, 16'hA5A5);
      send_request(mhq_pkg::REQ_PUSH, 16'h0005, 16'h0004);
      send_request(mhq_pkg::REQ_PUSH, 16'h0000, 16'hFFFF);
      repeat (10) send_request(mhq_pkg::REQ_POP, '0, '0);

      repeat (150) send_random(60);

      // Fill to capacity, then knock on the full heap a few times.
      while (fill_level < HEAP_DEPTH) send_random(95);
      repeat (6) send_request(mhq_pkg::REQ_PUSH, pick_key(), pick_payload());
      send_request(mhq_pkg::REQ_POP, '0, '0);
      repeat (3) send_request(mhq_pkg::REQ_PUSH, pick_key(), pick_payload());

      while (fill_level > 0) send_random(5);
      repeat (4) send_request(mhq_pkg::REQ_POP, pick_key(), pick_payload());
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("four_ary_min_heap_queue: match");
      end else begin
         $display("four_ary_min_heap_queue: mismatch");
      end
      $finish;
   end

endmodule
